// File: rtl/dmbc_pkg.sv
// shared types, constants and helpers for the direct-mapped block cache
`default_nettype none

package dmbc_pkg;

  // default geometry
  localparam int SLOTS_DEF       = 256;
  localparam int BLOCK_WORDS_DEF = 64;

  // fixed field widths
  localparam int BLK_W   = 32;
  localparam int WIDX_W  = 6;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 32;

  // cycles of the reciprocal slot reduction
  localparam int MOD_STEPS = 4;

  // one entry of the tag memory
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] tag;
  } tag_entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_TAG_RD,
    ST_TAG_CHK,
    ST_STREAM
  } state_t;

  // saturating increment of a statistics counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/direct_mapped_block_cache_top.sv
// direct-mapped block cache: tag and data memories with a read-modify-write sequencer
// Reset: a clearing pass writes every tag entry invalid; busy stays high during it.
// Every item first reduces block_number modulo SLOTS by a reciprocal multiplication,
// then reads the tag memory and checks it.
// A set or a get miss returns to idle after the tag check; a miss result is registered
// from the tag check. A hit streams BLOCK_WORDS words, one per cycle from the data memory
// read port; busy stays high until the last word has been read.
// The receiver cannot stall: each result is on the ports for one cycle under done.
`default_nettype none

module direct_mapped_block_cache_top #(
  parameter int SLOTS       = dmbc_pkg::SLOTS_DEF,
  parameter int BLOCK_WORDS = dmbc_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         mode,
  input  wire logic [dmbc_pkg::BLK_W-1:0]   block_number,
  input  wire logic [dmbc_pkg::WIDX_W-1:0]  word_index,
  input  wire logic [dmbc_pkg::WORD_W-1:0]  write_word,
  output logic                              done,
  output logic [dmbc_pkg::WORD_W-1:0]       read_word,
  output logic                              hit,
  output logic                              last_word,
  output logic [dmbc_pkg::COUNT_W-1:0]      hit_total,
  output logic [dmbc_pkg::COUNT_W-1:0]      miss_total,
  output logic [dmbc_pkg::COUNT_W-1:0]      set_total,
  output logic [dmbc_pkg::COUNT_W-1:0]      overwrite_total
);

  import dmbc_pkg::*;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_LOG = $clog2(SLOTS);
  localparam int REM_W    = SLOT_W + 1;
  localparam int DEPTH    = SLOTS * BLOCK_WORDS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int K_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int CNT_W    = $clog2(MOD_STEPS);

  // truncated reciprocal of SLOTS, at most 33 bits
  localparam logic [2*BLK_W-1:0] RECIP =
    ((2*BLK_W)'(1) << (BLK_W + SLOT_LOG)) / (2*BLK_W)'(SLOTS);
  localparam logic [BLK_W-1:0]   RECIP_LO = RECIP[BLK_W-1:0];
  localparam logic               RECIP_HI = RECIP[BLK_W];

  // state and registers
  state_t              state, state_next;
  logic [SLOT_W-1:0]   clr_idx;
  logic                req_mode;
  logic [BLK_W-1:0]    req_blk;
  logic [WIDX_W-1:0]   req_widx;
  logic [WORD_W-1:0]   req_wdata;
  logic [2*BLK_W-1:0]  prod;
  logic [2*BLK_W:0]    prod_sum;
  logic [BLK_W-1:0]    quot;
  logic [REM_W-1:0]    quot_s;
  logic [CNT_W-1:0]    div_cnt;
  logic [SLOT_W-1:0]   rem;
  logic [REM_W-1:0]    rem_work;
  logic [SLOT_W-1:0]   rem_step;
  logic [ADDR_W-1:0]   base;
  logic [K_W-1:0]      word_k;
  tag_entry_t          tag_q;
  logic [WORD_W-1:0]   data_q;

  // memories
  tag_entry_t          tag_mem [SLOTS];
  logic [WORD_W-1:0]   data_mem [DEPTH];

  // memory control
  logic                tag_we;
  logic [SLOT_W-1:0]   tag_waddr;
  tag_entry_t          tag_wdata;
  logic                tag_re;
  logic                data_we;
  logic [ADDR_W-1:0]   data_waddr;
  logic                data_re;
  logic [ADDR_W-1:0]   data_raddr;

  // decisions
  logic                accept;
  logic                tag_match;
  logic                widx_ok;
  logic                last_k;

  assign accept    = start && !busy;
  assign tag_match = tag_q.valid && (tag_q.tag == req_blk);
  assign widx_ok   = {1'b0, req_widx} < (WIDX_W + 1)'(BLOCK_WORDS);
  assign last_k    = (word_k == K_W'(BLOCK_WORDS - 1));
  assign read_word = hit ? data_q : '0;

  // reciprocal slot reduction: the quotient estimate is low by at most one
  always_comb begin
    prod_sum = {1'b0, prod} + (RECIP_HI ? {1'b0, req_blk, {BLK_W{1'b0}}} : '0);
    rem_work = REM_W'(req_blk) - quot_s;
    if (rem_work >= REM_W'(SLOTS)) begin
      rem_work = rem_work - REM_W'(SLOTS);
    end
    rem_step = rem_work[SLOT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SLOT_W'(SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (div_cnt == CNT_W'(MOD_STEPS - 1)) state_next = ST_TAG_RD;
      end
      ST_TAG_RD: state_next = ST_TAG_CHK;
      ST_TAG_CHK: begin
        if (!req_mode && tag_match) state_next = ST_STREAM;
        else state_next = ST_IDLE;
      end
      ST_STREAM: begin
        if (last_k) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory strobes
  always_comb begin
    busy       = (state != ST_IDLE);
    tag_we     = 1'b0;
    tag_waddr  = rem;
    tag_wdata  = '{valid: 1'b1, tag: req_blk};
    tag_re     = (state == ST_TAG_RD);
    data_we    = 1'b0;
    data_waddr = base + ADDR_W'(req_widx);
    data_re    = (state == ST_STREAM);
    data_raddr = base + ADDR_W'(word_k);
    case (state)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx;
        tag_wdata = '{valid: 1'b0, tag: '0};
      end
      ST_TAG_CHK: begin
        if (req_mode && widx_ok) begin
          tag_we  = 1'b1;
          data_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_TAG_CHK && !req_mode && !tag_match) done <= 1'b1;
      if (state == ST_STREAM) done <= 1'b1;
    end
  end

  // statistics counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total       <= '0;
      miss_total      <= '0;
      set_total       <= '0;
      overwrite_total <= '0;
    end else if (state == ST_TAG_CHK) begin
      if (!req_mode) begin
        if (tag_match) hit_total <= sat_inc(hit_total);
        else if (tag_q.valid) miss_total <= sat_inc(miss_total);
      end else if (widx_ok && req_widx == '0) begin
        set_total <= sat_inc(set_total);
        if (tag_q.valid) overwrite_total <= sat_inc(overwrite_total);
      end
    end
  end

  // request capture, slot reduction pipeline and stream position
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_blk   <= block_number;
      req_widx  <= word_index;
      req_wdata <= write_word;
      div_cnt   <= '0;
      rem       <= '0;
    end
    if (state == ST_MOD) begin
      prod    <= (2*BLK_W)'(req_blk) * (2*BLK_W)'(RECIP_LO);
      quot    <= BLK_W'(prod_sum >> (BLK_W + SLOT_LOG));
      quot_s  <= REM_W'(quot[REM_W-1:0] * REM_W'(SLOTS));
      rem     <= rem_step;
      div_cnt <= div_cnt + 1'b1;
    end
    if (state == ST_TAG_RD) base <= ADDR_W'(rem) * ADDR_W'(BLOCK_WORDS);
    if (state == ST_TAG_CHK) word_k <= '0;
    if (state == ST_STREAM) begin
      word_k    <= word_k + 1'b1;
      hit       <= 1'b1;
      last_word <= last_k;
    end
    if (state == ST_TAG_CHK && !req_mode && !tag_match) begin
      hit       <= 1'b0;
      last_word <= 1'b1;
    end
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (tag_re) tag_q <= tag_mem[rem];
  end

  // data memory
  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_waddr] <= req_wdata;
    if (data_re) data_q <= data_mem[data_raddr];
  end

  // a non-hit result always closes its get
  a_miss_is_last: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> last_word)
    else $error("non-hit result without last marker");

  // every stream cycle delivers a hit word in the next cycle
  a_stream_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_STREAM |=> done && hit)
    else $error("stream read without result transfer");

  // hit counter never goes backward
  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hit_total >= $past(hit_total))
    else $error("hit counter decreased");

  // no result while the tag clearing pass runs
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !done)
    else $error("result during clearing pass");

endmodule

`default_nettype wire

// File: bench/dmbc_tb_pkg.sv
`timescale 1ns / 1ps
// operation codes shared by the block cache testbench and its checker
package dmbc_tb_pkg;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_SET = 1'b1
  } cache_mode_t;

endpackage

// File: bench/dmbc_checker.sv
`timescale 1ns / 1ps
// scoreboard for the block cache: mirrors slots, block data and counters, checks every result

module dmbc_checker #(
  parameter int SLOTS       = 256,
  parameter int BLOCK_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        mode,
  input  logic [31:0] block_number,
  input  logic [5:0]  word_index,
  input  logic [63:0] write_word,
  input  logic        done,
  input  logic [63:0] read_word,
  input  logic        hit,
  input  logic        last_word,
  input  logic [31:0] hit_total,
  input  logic [31:0] miss_total,
  input  logic [31:0] set_total,
  input  logic [31:0] overwrite_total,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  // one predicted result transfer
  typedef struct packed {
    logic [63:0] word;
    logic        hit;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] sets;
    logic [31:0] overwrites;
  } cache_result_t;

  cache_result_t due_results[$];

  // mirrored cache contents and statistics
  logic        line_valid [SLOTS];
  logic [31:0] line_tag   [SLOTS];
  logic [63:0] line_data  [SLOTS*BLOCK_WORDS];
  logic [31:0] hit_cnt, miss_cnt, set_cnt, ovw_cnt;

  function automatic logic [31:0] sat_bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic queue_result(input logic [63:0] w, input logic h, input logic l);
    cache_result_t r;
    r.word       = w;
    r.hit        = h;
    r.last       = l;
    r.hits       = hit_cnt;
    r.misses     = miss_cnt;
    r.sets       = set_cnt;
    r.overwrites = ovw_cnt;
    due_results.push_back(r);
  endtask

  // apply one accepted command and queue the results it causes
  task automatic model_cache_op(input logic m, input logic [31:0] blk,
                                input logic [5:0] widx, input logic [63:0] wdata);
    int slot;
    int base;
    slot = int'(blk % SLOTS);
    base = slot * BLOCK_WORDS;
    if (m == dmbc_tb_pkg::MODE_GET) begin
      if (!line_valid[slot]) begin
        queue_result(64'd0, 1'b0, 1'b1);
      end else if (line_tag[slot] != blk) begin
        miss_cnt = sat_bump(miss_cnt);
        queue_result(64'd0, 1'b0, 1'b1);
      end else begin
        hit_cnt = sat_bump(hit_cnt);
        for (int k = 0; k < BLOCK_WORDS; k++)
          queue_result(line_data[base+k], 1'b1, k == BLOCK_WORDS - 1);
      end
    end else if (widx < BLOCK_WORDS) begin
      // word zero marks a new block set, an overwrite if the slot was taken
      if (widx == 0) begin
        set_cnt = sat_bump(set_cnt);
        if (line_valid[slot])
          ovw_cnt = sat_bump(ovw_cnt);
      end
      line_data[base+widx] = wdata;
      line_tag[slot]       = blk;
      line_valid[slot]     = 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_transfer();
    cache_result_t e;
    if (due_results.size() == 0) begin
      $display("%0t: result transfer with none expected: read_word %0h hit %0b last %0b",
               $time, read_word, hit, last_word);
      fail_count++;
    end else begin
      e = due_results.pop_front();
      checked++;
      compare_field("read_word", e.word, read_word);
      compare_field("hit", e.hit, hit);
      compare_field("last_word", e.last, last_word);
      compare_field("hit_total", e.hits, hit_total);
      compare_field("miss_total", e.misses, miss_total);
      compare_field("set_total", e.sets, set_total);
      compare_field("overwrite_total", e.overwrites, overwrite_total);
    end
  endtask

  // results are checked before the command of the same edge is modeled
  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++)
        line_valid[s] = 1'b0;
      hit_cnt    = '0;
      miss_cnt   = '0;
      set_cnt    = '0;
      ovw_cnt    = '0;
      fail_count = 0;
      checked    = 0;
      due_results.delete();
    end else begin
      if (done)
        check_transfer();
      if (start && !busy)
        model_cache_op(mode, block_number, word_index, write_word);
    end
    pending <= due_results.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// block cache testbench: reset, directed commands, then block fills and mixed gets and sets

module tb;

  import dmbc_tb_pkg::*;

  localparam int SLOTS       = dmbc_pkg::SLOTS_DEF;
  localparam int BLOCK_WORDS = dmbc_pkg::BLOCK_WORDS_DEF;
  localparam int SLOT_BITS   = $clog2(SLOTS);

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        mode;
  logic [31:0] block_number;
  logic [5:0]  word_index;
  logic [63:0] write_word;
  logic        done;
  logic [63:0] read_word;
  logic        hit;
  logic        last_word;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] set_total;
  logic [31:0] overwrite_total;

  int fail_count;
  int pending;
  int checked;

  // stimulus-side view of the slots, used to steer gets toward hits
  logic                   sh_valid   [SLOTS];
  logic [31:0]            sh_tag     [SLOTS];
  logic [BLOCK_WORDS-1:0] sh_written [SLOTS];
  logic [31:0]            hi_pool    [4];
  int                     full_slots[$];

  int n_set, n_get, n_hit, n_miss, n_empty;

  direct_mapped_block_cache_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .block_number    (block_number),
    .word_index      (word_index),
    .write_word      (write_word),
    .done            (done),
    .read_word       (read_word),
    .hit             (hit),
    .last_word       (last_word),
    .hit_total       (hit_total),
    .miss_total      (miss_total),
    .set_total       (set_total),
    .overwrite_total (overwrite_total)
  );

  dmbc_checker #(
    .SLOTS       (SLOTS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .block_number    (block_number),
    .word_index      (word_index),
    .write_word      (write_word),
    .done            (done),
    .read_word       (read_word),
    .hit             (hit),
    .last_word       (last_word),
    .hit_total       (hit_total),
    .miss_total      (miss_total),
    .set_total       (set_total),
    .overwrite_total (overwrite_total),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one command transfer; start stays high on return
  task automatic send_item(input cache_mode_t m, input logic [31:0] blk,
                           input logic [5:0] widx, input logic [63:0] data);
    int slot;
    slot = int'(blk % SLOTS);
    if (m == MODE_GET) begin
      n_get++;
      if (!sh_valid[slot])
        n_empty++;
      else if (sh_tag[slot] != blk)
        n_miss++;
      else
        n_hit++;
    end else begin
      n_set++;
      if (widx < BLOCK_WORDS) begin
        sh_valid[slot]         = 1'b1;
        sh_tag[slot]           = blk;
        sh_written[slot][widx] = 1'b1;
      end
    end
    start        <= 1'b1;
    mode         <= m;
    block_number <= blk;
    word_index   <= widx;
    write_word   <= data;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle(input int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [63:0] rand_data();
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_slot();
    int r;
    r = $urandom_range(99);
    if (r < 60 && full_slots.size() > 0)
      return full_slots[$urandom_range(full_slots.size() - 1)];
    if (r < 85) begin
      case ($urandom_range(3))
        0:       return 0;
        1:       return SLOTS - 1;
        2:       return 1;
        default: return SLOTS / 2;
      endcase
    end
    return $urandom_range(SLOTS - 1);
  endfunction

  function automatic logic [31:0] pick_block(input int slot);
    logic [31:0] hi;
    hi = ($urandom_range(7) == 0) ? $urandom : hi_pool[$urandom_range(3)];
    return (hi << SLOT_BITS) | 32'(slot);
  endfunction

  // write every word of one block in shuffled order
  task automatic fill_block(input logic [31:0] blk, input int pct);
    int order[BLOCK_WORDS];
    int j;
    int tmp;
    for (int k = 0; k < BLOCK_WORDS; k++)
      order[k] = k;
    for (int k = BLOCK_WORDS - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < BLOCK_WORDS; k++) begin
      maybe_idle(pct);
      send_item(MODE_SET, blk, 6'(order[k]), rand_data());
    end
    full_slots.push_back(int'(blk % SLOTS));
  endtask

  // one random get or set; gets never hit a block with unwritten words
  task automatic random_op();
    int          slot;
    logic [31:0] blk;
    slot = pick_slot();
    blk  = pick_block(slot);
    if ($urandom_range(1) == 0) begin
      if (sh_valid[slot] && (&sh_written[slot]) && $urandom_range(99) < 60)
        blk = sh_tag[slot];
      if (sh_valid[slot] && sh_tag[slot] == blk && !(&sh_written[slot]))
        blk = blk ^ (32'hFFFF_FFFF << SLOT_BITS);
      send_item(MODE_GET, blk, 6'($urandom_range(63)), rand_data());
    end else begin
      if (sh_valid[slot] && $urandom_range(1) == 0)
        blk = sh_tag[slot];
      send_item(MODE_SET, blk, ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(63)),
                rand_data());
    end
  endtask

  task automatic run_phase(input int pct, input logic [31:0] fill_blk, input int n_ops,
                           input bit pause_midway);
    fill_block(fill_blk, pct);
    for (int i = 0; i < n_ops; i++) begin
      if (pause_midway && i == n_ops / 2)
        drain();
      maybe_idle(pct);
      random_op();
    end
  endtask

  // stimulus and verdict
  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    mode         <= 1'b0;
    block_number <= '0;
    word_index   <= '0;
    write_word   <= '0;
    for (int s = 0; s < SLOTS; s++) begin
      sh_valid[s]   = 1'b0;
      sh_written[s] = '0;
    end
    hi_pool[0] = 32'd0;
    hi_pool[1] = 32'hFFFF_FFFF;
    hi_pool[2] = $urandom;
    hi_pool[3] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty slots, tag mismatch, overwrite of the same block
    send_item(MODE_GET, 32'h0000_0000, 6'd63, '1);
    send_item(MODE_GET, 32'hFFFF_FFFF, 6'd0, 64'd0);
    send_item(MODE_SET, 32'hFFFF_FFFF, 6'd63, '1);
    send_item(MODE_GET, 32'h0000_00FF, 6'd0, 64'd0);
    send_item(MODE_SET, 32'hFFFF_FFFF, 6'd0, 64'd0);
    send_item(MODE_SET, 32'hFFFF_FFFF, 6'd0, 64'h5555_5555_5555_5555);
    send_item(MODE_SET, 32'h0000_0100, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(MODE_GET, 32'h0000_0000, 6'd21, 64'd1);
    send_item(MODE_SET, 32'h8000_0001, 6'd31, 64'h8000_0000_0000_0000);
    send_item(MODE_GET, 32'h0000_0001, 6'd42, 64'd0);
    drain();

    // random phases, each opening with a full block fill
    run_phase(9, $urandom, 56, 1'b1);
    run_phase(56, 32'hFFFF_FFFF, 56, 1'b0);
    run_phase(0, 32'h0000_0000, 56, 1'b0);

    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d gets (%0d hits, %0d tag misses, %0d on empty slots), %0d set words",
             n_get, n_hit, n_miss, n_empty, n_set);
    $display("%0d result transfers compared field by field", checked);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
